>>> hw/rtl/rws_pkg.sv
// Shared types and constants for the roulette wheel selection block.
`timescale 1ns / 1ps

package rws_pkg;

	// default sizes
	localparam int POP_MAX_DEF   = 256;
	localparam int FRAC_BITS_DEF = 16;

	// fixed field widths
	localparam int FIT_W  = 16;   // signed fitness
	localparam int OFS_W  = 16;   // weight offset
	localparam int WGT_W  = 17;   // clamped weight, fitness + offset
	localparam int POP_W  = 9;    // population_size register
	localparam int EIDX_W = 8;    // entry_index / selected_index
	localparam int RND_W  = 16;   // random_fraction
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;

	// item kinds, carried on tuser
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	// register word select (paddr[2])
	localparam logic REG_POP_SIZE   = 1'b0;
	localparam logic REG_WEIGHT_OFS = 1'b1;

	// accumulator control
	typedef struct packed {
		logic clr;
		logic en;
	} acc_ctl_t;

endpackage

>>> hw/rtl/rws_table.sv
// Fitness table: single write port, single registered read port.
`timescale 1ns / 1ps

module rws_table import rws_pkg::*; #(
	parameter int POP_MAX = POP_MAX_DEF,
	localparam int IDX_W = $clog2(POP_MAX)
) (
	input  logic                    clk,
	input  logic                    we,
	input  logic [IDX_W-1:0]        waddr,
	input  logic signed [FIT_W-1:0] wdata,
	input  logic [IDX_W-1:0]        raddr,
	output logic signed [FIT_W-1:0] rdata
);

	logic signed [FIT_W-1:0] mem [POP_MAX];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/rws_accum.sv
// Shared weight accumulator: clamp, add and reach-target compare.
`timescale 1ns / 1ps

module rws_accum import rws_pkg::*; #(
	parameter int TOT_W     = WGT_W + 8,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	localparam int GOAL_W   = TOT_W + FRAC_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  acc_ctl_t                ctl,
	input  logic signed [FIT_W-1:0] fit,
	input  logic [OFS_W-1:0]        ofs,
	input  logic [GOAL_W-1:0]       goal,
	output logic [TOT_W-1:0]        sum,
	output logic                    reach
);

	logic [TOT_W-1:0]         acc_q;
	logic signed [WGT_W:0]    wraw;
	logic [WGT_W-1:0]         wgt;

	// fitness + offset, negative weighs nothing
	assign wraw  = $signed({{(WGT_W+1-FIT_W){fit[FIT_W-1]}}, fit})
	             + $signed({{(WGT_W+1-OFS_W){1'b0}}, ofs});
	assign wgt   = wraw[WGT_W] ? '0 : wraw[WGT_W-1:0];
	assign sum   = acc_q + TOT_W'(wgt);
	assign reach = {sum, {FRAC_BITS{1'b0}}} >= goal;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			acc_q <= sum;
		end
	end

endmodule

>>> hw/rtl/roulette_wheel_selection.sv
// Roulette wheel selection top level: stream ports, register port and sequencer.
`timescale 1ns / 1ps

// Fitness-proportional selection over a table of POP_MAX signed fitness entries.
// A load item (tuser = 0) writes one entry and the port stays
// ready, so loads stream back to back. A select item (tuser = 1) returns one
// index: weights are fitness + weight_offset clamped at zero, over the first
// population_size entries (0 counts as 1, larger than POP_MAX as POP_MAX). Pass
// one sums the weights, one multiply forms total * fraction, pass two walks the
// entries until the partial sum, scaled by 2^FRAC_BITS, reaches that target, or
// answers the last active entry. The walk stops early when an entry reaches the
// target. The table's single read port feeds one shared accumulator, one entry
// a cycle. Input is not ready while a select is in progress. After reset the
// table is cleared by a pass over all POP_MAX entries, during which no item is
// taken; register writes are accepted throughout. The result sits in an output
// register, so a new item can be taken while it waits.

module roulette_wheel_selection import rws_pkg::*; #(
	parameter int POP_MAX   = POP_MAX_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// input items
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [39:0]       s_axis_tdata,   // entry_index[7:0], fitness_value[23:8],
	                                          // random_fraction[39:24]
	input  logic              s_axis_tuser,   // op
	// result items
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [7:0]        m_axis_tdata,   // selected_index[7:0]
	// register port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int IDX_W  = $clog2(POP_MAX);
	localparam int NW     = (IDX_W + 1 > POP_W) ? IDX_W + 1 : POP_W;
	localparam int TOT_W  = WGT_W + IDX_W;
	localparam int GOAL_W = TOT_W + FRAC_BITS;
	localparam int KW     = (FRAC_BITS < RND_W) ? FRAC_BITS : RND_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SUM,
		ST_MUL,
		ST_WALK,
		ST_OUT
	} state_t;

	state_t state_q;

	// item fields
	logic [EIDX_W-1:0]       in_idx;
	logic signed [FIT_W-1:0] in_fit;
	logic [RND_W-1:0]        in_rnd;
	logic                    in_acc;

	assign in_idx = s_axis_tdata[7:0];
	assign in_fit = s_axis_tdata[23:8];
	assign in_rnd = s_axis_tdata[39:24];
	assign in_acc = s_axis_tvalid && s_axis_tready;

	// registers
	logic [POP_W-1:0] pop_size_q;
	logic [OFS_W-1:0] wofs_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_WEIGHT_OFS) ? APB_DW'(wofs_q) : APB_DW'(pop_size_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q <= POP_W'(256);
			wofs_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_POP_SIZE:   pop_size_q <= pwdata[POP_W-1:0];
				REG_WEIGHT_OFS: wofs_q     <= pwdata[OFS_W-1:0];
				default:        ;
			endcase
		end
	end

	// last active index: size 0 acts as 1, above POP_MAX saturates
	logic [NW-1:0]    pop_ext;
	logic [IDX_W-1:0] n_last;

	assign pop_ext = NW'(pop_size_q);

	always_comb begin
		if (pop_ext == '0) begin
			n_last = '0;
		end else if (pop_ext > NW'(POP_MAX)) begin
			n_last = IDX_W'(POP_MAX - 1);
		end else begin
			n_last = IDX_W'(pop_ext - NW'(1));
		end
	end

	// sequencer state
	logic [IDX_W-1:0]  addr_q;      // read address, also clear pointer
	logic              issue_q;     // a read goes out this cycle
	logic              rv_s1;       // read data valid
	logic [IDX_W-1:0]  ridx_s1;     // index of read data
	logic [IDX_W-1:0]  n_last_q;
	logic [KW-1:0]     k_q;
	logic [TOT_W-1:0]  total_q;
	logic [GOAL_W-1:0] goal_q;
	logic [IDX_W-1:0]  res_q;
	logic              m_valid_q;
	logic [7:0]        m_data_q;

	// table and shared accumulator
	logic                    tb_we;
	logic [IDX_W-1:0]        tb_waddr;
	logic signed [FIT_W-1:0] tb_wdata;
	logic signed [FIT_W-1:0] tb_rdata;
	logic                    load_ok;
	acc_ctl_t                acc_ctl;
	logic [TOT_W-1:0]        acc_sum;
	logic                    acc_reach;
	logic                    out_free;

	assign load_ok  = in_acc && (s_axis_tuser == OP_LOAD) && (NW'(in_idx) < NW'(POP_MAX));
	assign tb_we    = (state_q == ST_CLEAR) || load_ok;
	assign tb_waddr = (state_q == ST_CLEAR) ? addr_q : IDX_W'(in_idx);
	assign tb_wdata = (state_q == ST_CLEAR) ? '0 : in_fit;

	assign acc_ctl.clr = (in_acc && (s_axis_tuser == OP_SELECT)) || (state_q == ST_MUL);
	assign acc_ctl.en  = rv_s1 && ((state_q == ST_SUM) || (state_q == ST_WALK));

	assign out_free = !m_valid_q || m_axis_tready;

	rws_table #(
		.POP_MAX (POP_MAX)
	) u_table (
		.clk   (clk),
		.we    (tb_we),
		.waddr (tb_waddr),
		.wdata (tb_wdata),
		.raddr (addr_q),
		.rdata (tb_rdata)
	);

	rws_accum #(
		.TOT_W     (TOT_W),
		.FRAC_BITS (FRAC_BITS)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.fit    (tb_rdata),
		.ofs    (wofs_q),
		.goal   (goal_q),
		.sum    (acc_sum),
		.reach  (acc_reach)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			addr_q    <= '0;
			issue_q   <= 1'b0;
			rv_s1     <= 1'b0;
			ridx_s1   <= '0;
			n_last_q  <= '0;
			k_q       <= '0;
			total_q   <= '0;
			goal_q    <= '0;
			res_q     <= '0;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			rv_s1   <= issue_q;
			ridx_s1 <= addr_q;
			if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == IDX_W'(POP_MAX - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc && (s_axis_tuser == OP_SELECT)) begin
						k_q      <= in_rnd[KW-1:0];
						n_last_q <= n_last;
						addr_q   <= '0;
						issue_q  <= 1'b1;
						state_q  <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (issue_q) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == n_last_q) begin
							issue_q <= 1'b0;
						end
					end
					if (rv_s1 && (ridx_s1 == n_last_q)) begin
						total_q <= acc_sum;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					goal_q  <= GOAL_W'(total_q) * GOAL_W'(k_q);
					addr_q  <= '0;
					issue_q <= 1'b1;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (issue_q) begin
						addr_q <= addr_q + 1'b1;
						if (addr_q == n_last_q) begin
							issue_q <= 1'b0;
						end
					end
					// first entry reaching the target, else the last one
					if (rv_s1 && (acc_reach || (ridx_s1 == n_last_q))) begin
						res_q   <= ridx_s1;
						issue_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					issue_q <= 1'b0;
					addr_q  <= '0;
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_data_q  <= 8'(res_q);
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/rws_checker.sv
// Port-level checks for the roulette wheel selection block, bound to the top level.
`timescale 1ns / 1ps

module rws_checker import rws_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              s_axis_tvalid,
	input logic              s_axis_tready,
	input logic              s_axis_tuser,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [7:0]        m_axis_tdata
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// a select item makes the block busy
	a_sel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_SELECT) |=> !s_axis_tready)
		else $error("ready after select item");

	// a load item leaves the input ready
	a_load_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_LOAD) |=> s_axis_tready)
		else $error("not ready after load item");

	// a result appears only as the block returns to idle
	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> s_axis_tready)
		else $error("result raised while busy");

endmodule

bind roulette_wheel_selection rws_checker u_rws_checker (.*);

>>> tb/sv/roulette_wheel_selection_test.sv
// Self-checking testbench for the roulette wheel selection block.
`timescale 1ns / 1ps

// Stimulus runs in two parts. The first is a short table of directed items, with
// the answer typed in where it is obvious, e.g. an empty wheel, a wheel with all
// its weight on one entry, or an exact tie on the target. The second part is a
// run of register settings, each followed by random load and select items.
// A local copy of the fitness table and the two registers predicts the index
// chosen by the other select items. Both stream sides idle at random. In one phase
// the receiver holds off long enough to fill the block and stall its input.

module roulette_wheel_selection_test;
	import rws_pkg::*;

	localparam int POP_MAX    = POP_MAX_DEF;
	localparam int FRAC_BITS  = FRAC_BITS_DEF;
	localparam int SETTLE     = 16;              // covers a load still being written
	localparam int END_WAIT   = 2 * POP_MAX + 16; // one full select, with margin
	localparam int NDIR       = 22;
	localparam int NPHASE     = 14;
	localparam int HOLD_PHASE = 5;
	localparam int MAX_PRINTS = 40;

	// register settings per random phase: extremes first, out-of-range sizes too
	localparam int PHASE_POP [NPHASE] = '{1, 0, 2, 256, 7, 16, 511, 3, 32, 300, 64, 5,
		12, 128};
	localparam int PHASE_OFS [NPHASE] = '{0, 300, 32768, 0, 65535, 1000, 32768, 0,
		20000, 65535, 5, 32767, 0, 128};

	typedef struct packed {
		logic        op;
		logic [7:0]  idx;
		logic [15:0] fit;
		logic [15:0] frac;
		logic        known;  // want is typed in, not predicted
		logic [7:0]  want;
	} stim_row_t;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [39:0]       s_axis_tdata  = '0;   // entry_index[7:0], fitness_value[23:8],
	                                         // random_fraction[39:24]
	logic              s_axis_tuser  = OP_LOAD; // op
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [7:0]        m_axis_tdata;         // selected_index[7:0]
	logic              psel          = 1'b0;
	logic              penable       = 1'b0;
	logic              pwrite        = 1'b0;
	logic [APB_AW-1:0] paddr         = '0;
	logic [APB_DW-1:0] pwdata        = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// predictor state
	logic signed [15:0] fit_table [POP_MAX];
	int                 pop_size   = 256;
	int                 weight_ofs = 0;
	logic [7:0]         expected_picks [$];

	int        errors     = 0;
	bit        quiet      = 1'b0;  // no idling on either side
	int        hold_left  = 0;     // long receiver hold-off, counted by the receiver
	int        stall_left = 0;
	stim_row_t directed_rows [NDIR];

	roulette_wheel_selection #(
		.POP_MAX  (POP_MAX),
		.FRAC_BITS(FRAC_BITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// mostly back to back, now and then a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	// weight of one entry: fitness plus offset, never below zero
	function automatic int entry_weight(int i);
		int w;
		w = int'(fit_table[i]) + weight_ofs;
		return (w < 0) ? 0 : w;
	endfunction

	// index chosen for a select item under the current table and registers
	function automatic logic [7:0] pick_index(logic [15:0] frac);
		int      n;
		int      i;
		bit      hit;
		longint  total;
		longint  part;
		longint  goal;
		longint  k;
		n = pop_size;
		if (n == 0)
			n = 1;
		if (n > POP_MAX)
			n = POP_MAX;
		total = 0;
		for (i = 0; i < n; i++)
			total += entry_weight(i);
		k = frac;
		goal = total * k;
		part = 0;
		hit = 1'b0;
		i = 0;
		// first entry whose partial sum reaches r*W, else the last active one
		while (!hit && i < n - 1) begin
			part += entry_weight(i);
			if ((part << FRAC_BITS) >= goal)
				hit = 1'b1;
			else
				i++;
		end
		return i[7:0];
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (errors < MAX_PRINTS)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	// register write: setup phase, then access phase until pready, then idle
	task automatic apb_write(logic reg_sel, int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready)
			@(negedge clk);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (reg_sel == REG_POP_SIZE)
			pop_size = value & 'h1FF;
		else
			weight_ofs = value & 'hFFFF;
		@(posedge clk);
	endtask

	// offer one item, called at a rising edge; returns at the edge that takes it
	task automatic send_item(logic op, logic [7:0] idx, logic [15:0] fit,
		logic [15:0] frac, logic known, logic [7:0] want);
		int gap;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {frac, fit, idx};
		@(negedge clk);
		while (!s_axis_tready)
			@(negedge clk);
		// taken at the coming edge
		if (op == OP_LOAD)
			fit_table[idx] = fit;
		else
			expected_picks.push_back(known ? want : pick_index(frac));
		@(posedge clk);
	endtask

	// sender pauses until every result is back, then lets a load finish
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (expected_picks.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// random item, loads mostly aimed at active entries
	task automatic random_item(int n_eff);
		logic        op;
		logic [7:0]  idx;
		logic [15:0] fit;
		logic [15:0] frac;
		int          r;
		op  = ($urandom_range(0, 99) < 55) ? OP_LOAD : OP_SELECT;
		idx = 8'($urandom);
		if ($urandom_range(0, 4) != 0)
			idx = 8'($urandom_range(0, n_eff - 1));
		r = $urandom_range(0, 9);
		fit = (r == 0) ? 16'h7FFF : (r == 1) ? 16'h8000 : 16'($urandom);
		r = $urandom_range(0, 9);
		frac = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
		send_item(op, idx, fit, frac, 1'b0, 8'd0);
	endtask

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// result check, sampled mid-cycle ahead of the edge that takes the item
	initial begin
		forever begin
			@(negedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_picks.size() == 0)
					report_mismatch("result with nothing pending", m_axis_tdata, -1);
				else if (m_axis_tdata !== expected_picks[0]) begin
					report_mismatch("selected_index", m_axis_tdata, expected_picks[0]);
					void'(expected_picks.pop_front());
				end else
					void'(expected_picks.pop_front());
			end
		end
	end

	initial begin
		int n_eff;
		int count;
		for (int i = 0; i < POP_MAX; i++)
			fit_table[i] = '0;

		// registers at reset values: size 256, offset 0, table all zero
		directed_rows = '{
			// empty wheel: target zero, index 0 whatever the fraction
			'{OP_SELECT, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'd0},
			// all weight on the last entry
			'{OP_LOAD,   8'hFF, 16'h7FFF, 16'hFFFF, 1'b0, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 8'd255},
			'{OP_SELECT, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 8'd0},
			// most negative fitness weighs nothing
			'{OP_LOAD,   8'h00, 16'h8000, 16'h0000, 1'b0, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'h8000, 1'b1, 8'd255},
			// two equal halves at the ends of the table
			'{OP_LOAD,   8'h00, 16'h7FFF, 16'h0000, 1'b0, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'h0001, 1'b1, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 8'd255},
			// partial sum exactly on the target counts as reached
			'{OP_SELECT, 8'h00, 16'h0000, 16'h8000, 1'b1, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'h8001, 1'b0, 8'd0},
			'{OP_LOAD,   8'h80, 16'h0001, 16'hFFFF, 1'b0, 8'd0},
			'{OP_LOAD,   8'h7F, 16'hFFFF, 16'h0000, 1'b0, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'h8001, 1'b0, 8'd0},
			'{OP_LOAD,   8'hFF, 16'h0000, 16'h0000, 1'b0, 8'd0},
			'{OP_LOAD,   8'h01, 16'h5555, 16'hAAAA, 1'b0, 8'd0},
			'{OP_LOAD,   8'h02, 16'hAAAA, 16'h5555, 1'b0, 8'd0},
			'{OP_SELECT, 8'h55, 16'h5555, 16'h5555, 1'b0, 8'd0},
			'{OP_SELECT, 8'hAA, 16'hAAAA, 16'hAAAA, 1'b0, 8'd0},
			'{OP_SELECT, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 8'd0},
			// zero fraction always lands on entry 0
			'{OP_SELECT, 8'h00, 16'h0000, 16'h0000, 1'b1, 8'd0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// the block clears its table first; the handshake waits that out
		foreach (directed_rows[r])
			send_item(directed_rows[r].op, directed_rows[r].idx, directed_rows[r].fit,
				directed_rows[r].frac, directed_rows[r].known, directed_rows[r].want);

		for (int p = 0; p < NPHASE; p++) begin
			wait_drain();
			apb_write(REG_POP_SIZE, PHASE_POP[p]);
			apb_write(REG_WEIGHT_OFS, PHASE_OFS[p]);
			n_eff = (pop_size == 0) ? 1 : (pop_size > POP_MAX) ? POP_MAX : pop_size;

			if (p == HOLD_PHASE) begin
				// receiver holds off while selects keep coming: output register and
				// the walk both fill, and the input stalls
				quiet = 1'b1;
				hold_left = 400;
				repeat (6)
					send_item(OP_SELECT, 8'($urandom), 16'($urandom), 16'($urandom),
						1'b0, 8'd0);
				wait_drain();
			end

			// some phases run with no idling at all
			quiet = ($urandom_range(0, 4) == 0);
			// large wheels are slow, so fewer items there
			count = (n_eff >= 128) ? 40 : 140;
			repeat (count)
				random_item(n_eff);
		end

		wait_drain();
		quiet = 1'b0;
		// anything that turns up now was never asked for
		repeat (END_WAIT) @(posedge clk);

		if (errors == 0)
			$display("roulette_wheel_selection: match");
		else
			$display("roulette_wheel_selection: mismatch");
		$finish;
	end

	// hang guard, far beyond the slowest correct run
	initial begin
		#20ms;
		$display("roulette_wheel_selection: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/rws_pkg.sv
hw/rtl/rws_table.sv
hw/rtl/rws_accum.sv
hw/rtl/roulette_wheel_selection.sv
hw/rtl/rws_checker.sv
tb/sv/roulette_wheel_selection_test.sv
